// ===== hw/rtl/dual_pulse_occupancy_dust_meter_macros.svh =====
// Assertion macros shared by the dust meter RTL.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef DUAL_PULSE_OCCUPANCY_DUST_METER_MACROS_SVH
`define DUAL_PULSE_OCCUPANCY_DUST_METER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DPOD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dust meter same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DPOD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dust meter next-cycle check failed");

`endif

// ===== hw/rtl/dpod_pkg.sv =====
// Package for the dust meter: widths, constants, register indexes and types.
// No dependencies; used by dpod_div, dpod_lane, the top level and the testbench.
package dpod_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int STAMP_W = 32;
    localparam int OCC_W   = 32;
    localparam int CONC_W  = 29;
    localparam int RATIO_W = 23;
    localparam int MS_W    = 16;
    localparam int WGT_W   = 8;
    localparam int DIV_W   = 48;
    localparam int DVS_W   = 20;

    localparam logic [OCC_W-1:0]   OCC_MAX   = '1;
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
    localparam logic [CONC_W-1:0]  CONC_MAX  = '1;
    localparam logic [DVS_W-1:0]   RATIO_SCALE = 20'd10;
    localparam logic [MS_W-1:0]    SAMPLE_MS_RST = 16'd4000;
    localparam logic [WGT_W-1:0]   WEIGHT_RST    = 8'd1;

    typedef enum logic {
        REG_SAMPLE_MS     = 1'b0,
        REG_FILTER_WEIGHT = 1'b1
    } t_reg_index;

    typedef enum logic {
        OP_SAMPLE     = 1'b0,
        OP_PERIOD_END = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATIO_GO,
        S_RATIO_WAIT,
        S_SQ,
        S_CUBE,
        S_POLY,
        S_CONC,
        S_FMUL,
        S_FILT_GO,
        S_FILT_WAIT,
        S_DONE
    } t_lane_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_lane_stat;

endpackage

// ===== hw/rtl/dpod_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on dpod_pkg for default widths.
module dpod_div #(
    parameter int DW = dpod_pkg::DIV_W,
    parameter int VW = dpod_pkg::DVS_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;
    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_sub;
    logic          fits;

    always_comb begin
        rem_sh  = {r_rem, r_q[DW-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        fits    = rem_sh >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(DW);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_q   <= {r_q[DW-2:0], fits};
            r_rem <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== hw/rtl/dpod_lane.sv =====
// One sensor channel: edge tracking, occupancy total and the period-end curve
// and filter. Depends on dpod_pkg and dpod_div.
module dpod_lane #(
    parameter int TIME_WIDTH = dpod_pkg::TIME_WIDTH_DEF,
    parameter int FRAC_BITS  = dpod_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc_sample,
    input  logic                          i_acc_period,
    input  logic                          i_level,
    input  logic [dpod_pkg::STAMP_W-1:0]  i_time_us,
    input  logic [dpod_pkg::MS_W-1:0]     i_sample_ms,
    input  logic [dpod_pkg::WGT_W-1:0]    i_weight,
    input  logic                          i_take,
    output dpod_pkg::t_lane_stat          o_stat,
    output logic [dpod_pkg::CONC_W-1:0]   o_conc
);
    import dpod_pkg::*;

    localparam int SW  = ((TIME_WIDTH > OCC_W) ? TIME_WIDTH : OCC_W) + 1;
    localparam int PW  = 44;
    localparam int PSW = PW + FRAC_BITS;
    // Division by five of a 32-bit value as a reciprocal multiply, shifted by 34.
    localparam logic [31:0] DIV5_RECIP = 32'hCCCC_CCCD;
    // Smallest scaled value whose tenth no longer fits the concentration field.
    localparam logic [63:0] CONC_SAT_X = 64'd10 << CONC_W;

    t_lane_state r_state, n_state;

    logic                  r_last;
    logic [TIME_WIDTH-1:0] r_start;
    logic [OCC_W-1:0]      r_occ;
    logic [CONC_W-1:0]     r_filt;
    logic [RATIO_W-1:0]    r_r;
    logic [29:0]           r_r2;
    logic [36:0]           r_r3;
    logic [PW-1:0]         r_p;
    logic [CONC_W-1:0]     r_c;
    logic [36:0]           r_prod;

    logic [TIME_WIDTH-1:0] t_now;
    logic [TIME_WIDTH-1:0] diff;
    logic [SW-1:0]         occ_sum;
    logic [MS_W-1:0]       ms_eff;
    logic [WGT_W-1:0]      w_eff;
    logic [45:0]           sq;
    logic [52:0]           cube;
    logic [PW-1:0]         poly;
    logic [PSW-1:0]        p_sh;
    logic [63:0]           conc_x;
    logic                  conc_sat;
    logic [63:0]           conc_prod;

    logic                  div_start;
    logic [DIV_W-1:0]      div_dvd;
    logic [DVS_W-1:0]      div_dvs;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quot;

    dpod_div #(.DW(DIV_W), .VW(DVS_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        t_now   = TIME_WIDTH'(i_time_us);
        diff    = t_now - r_start;
        occ_sum = SW'(r_occ) + SW'(diff);
        ms_eff  = (i_sample_ms == '0) ? MS_W'(1) : i_sample_ms;
        w_eff   = (i_weight == '0) ? WGT_W'(1) : i_weight;
        sq      = 46'(r_r) * 46'(r_r);
        cube    = 53'(r_r2) * 53'(r_r);
        poly    = PW'(11) * PW'(r_r3) + PW'(5200) * PW'(r_r) - PW'(38) * PW'(r_r2);
        p_sh    = PSW'(r_p) << FRAC_BITS;
        // The tenth is taken as a halving followed by an exact division by five;
        // values that would overflow the field saturate in place of the product.
        conc_x    = 64'(p_sh >> 16);
        conc_sat  = (conc_x >= CONC_SAT_X);
        conc_prod = 64'(conc_x[32:1]) * 64'(DIV5_RECIP);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_acc_period) n_state = S_RATIO_GO;
            S_RATIO_GO:  n_state = S_RATIO_WAIT;
            S_RATIO_WAIT: if (div_done) n_state = S_SQ;
            S_SQ:        n_state = S_CUBE;
            S_CUBE:      n_state = S_POLY;
            S_POLY:      n_state = S_CONC;
            S_CONC:      n_state = S_FMUL;
            S_FMUL:      n_state = S_FILT_GO;
            S_FILT_GO:   n_state = S_FILT_WAIT;
            S_FILT_WAIT: if (div_done) n_state = S_DONE;
            S_DONE:      if (i_take) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Divider control per state.
    always_comb begin
        div_start = 1'b0;
        div_dvd   = DIV_W'({r_occ, 16'h0000});
        div_dvs   = DVS_W'(ms_eff) * RATIO_SCALE;
        unique case (r_state)
            S_RATIO_GO: div_start = 1'b1;
            S_FILT_GO: begin
                div_start = 1'b1;
                div_dvd   = DIV_W'(38'(r_c) + 38'(r_prod));
                div_dvs   = DVS_W'(w_eff);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b1;
            r_start <= '0;
            r_occ   <= '0;
            r_filt  <= '0;
        end else begin
            r_state <= n_state;
            if (i_acc_sample && (i_level != r_last)) begin
                r_last <= i_level;
                if (!i_level) begin
                    r_start <= t_now;
                end else if (occ_sum > SW'(OCC_MAX)) begin
                    r_occ <= OCC_MAX;
                end else begin
                    r_occ <= occ_sum[OCC_W-1:0];
                end
            end
            if (r_state == S_RATIO_GO) r_occ <= '0;
            if (r_state == S_FILT_WAIT && div_done) r_filt <= div_quot[CONC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RATIO_WAIT && div_done) begin
            r_r <= (div_quot > DIV_W'(RATIO_MAX)) ? RATIO_MAX : div_quot[RATIO_W-1:0];
        end
        if (r_state == S_SQ) r_r2 <= sq[45:16];
        if (r_state == S_CUBE) r_r3 <= cube[52:16];
        if (r_state == S_POLY) r_p <= poly;
        if (r_state == S_CONC) begin
            r_c <= conc_sat ? CONC_MAX : conc_prod[CONC_W+33:34];
        end
        if (r_state == S_FMUL) r_prod <= 37'(r_filt) * 37'(w_eff - WGT_W'(1));
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_conc      = r_filt;
endmodule

// ===== hw/rtl/dual_pulse_occupancy_dust_meter.sv =====
// Dual low-pulse-occupancy dust meter: top level with two channel lanes and the
// result register that merges them. Depends on dpod_pkg, dpod_lane, the macros.
//
// Usage. The input channel (i_in_valid / o_in_stall) carries items with an
// opcode, both sensor pin levels and a microsecond timestamp. A pin-sample
// item is absorbed without stalling and never produces a result. A period-end
// item starts both lanes, which run in lockstep; each lane does two serial
// divisions on its own divider (ratio, filter), a reciprocal multiply for the
// scaling and a handful of multiply steps. o_out_valid is set when the result
// is loaded after the filter division, and the input takes new items again
// from that same cycle on.
// While the lanes work, o_in_stall stays high. The result item (both filtered
// concentrations) then sits in an output register; once it is loaded the block
// takes new items again even while the receiver holds i_out_stall high, and a
// second period end waits in the lanes until that register has been taken.
// Configuration writes (sample period, filter weight) are always ready and are
// meant to be issued only while the block is idle.
// Reset clears pin history, occupancy totals, filter states, drops any pending
// result and restores the period to 4000 ms and the weight to 1.
`include "dual_pulse_occupancy_dust_meter_macros.svh"

module dual_pulse_occupancy_dust_meter #(
    parameter int TIME_WIDTH = dpod_pkg::TIME_WIDTH_DEF,
    parameter int FRAC_BITS  = dpod_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_opcode,
    input  logic                         i_level_coarse,
    input  logic                         i_level_fine,
    input  logic [dpod_pkg::STAMP_W-1:0] i_time_us,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [dpod_pkg::CONC_W-1:0]  o_conc_coarse,
    output logic [dpod_pkg::CONC_W-1:0]  o_conc_fine,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [dpod_pkg::MS_W-1:0]    i_cfg_data
);
    import dpod_pkg::*;

    logic [MS_W-1:0]   r_sample_ms;
    logic [WGT_W-1:0]  r_weight;
    logic              r_out_valid;
    logic [CONC_W-1:0] r_out_coarse;
    logic [CONC_W-1:0] r_out_fine;

    t_lane_stat        stat_coarse;
    t_lane_stat        stat_fine;
    logic [CONC_W-1:0] conc_coarse;
    logic [CONC_W-1:0] conc_fine;

    logic in_acc;
    logic acc_sample;
    logic acc_period;
    logic take;

    // The lanes hold the input while any period-end work is outstanding.
    assign o_in_stall  = stat_coarse.busy | stat_fine.busy;
    assign o_cfg_ready = 1'b1;

    assign in_acc     = i_in_valid & ~o_in_stall;
    assign acc_sample = in_acc & (i_opcode == OP_SAMPLE);
    assign acc_period = in_acc & (i_opcode == OP_PERIOD_END);

    // Both lanes finish together; hand off once the output register is free.
    assign take = stat_coarse.done & stat_fine.done & (~r_out_valid | ~i_out_stall);

    dpod_lane #(.TIME_WIDTH(TIME_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_coarse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc_sample (acc_sample),
        .i_acc_period (acc_period),
        .i_level      (i_level_coarse),
        .i_time_us    (i_time_us),
        .i_sample_ms  (r_sample_ms),
        .i_weight     (r_weight),
        .i_take       (take),
        .o_stat       (stat_coarse),
        .o_conc       (conc_coarse)
    );

    dpod_lane #(.TIME_WIDTH(TIME_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_fine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc_sample (acc_sample),
        .i_acc_period (acc_period),
        .i_level      (i_level_fine),
        .i_time_us    (i_time_us),
        .i_sample_ms  (r_sample_ms),
        .i_weight     (r_weight),
        .i_take       (take),
        .o_stat       (stat_fine),
        .o_conc       (conc_fine)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_ms <= SAMPLE_MS_RST;
            r_weight    <= WEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_SAMPLE_MS:     r_sample_ms <= i_cfg_data;
                REG_FILTER_WEIGHT: r_weight    <= i_cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Merge stage: one result item carrying both lanes' values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_coarse <= conc_coarse;
            r_out_fine   <= conc_fine;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_conc_coarse = r_out_coarse;
    assign o_conc_fine   = r_out_fine;

    `DPOD_ASSERT_IMP(a_lanes_lockstep, 1'b1, stat_coarse.done == stat_fine.done)
    `DPOD_ASSERT_NXT(a_take_loads_out, take, o_out_valid)
    `DPOD_ASSERT_NXT(a_period_starts_work, acc_period, o_in_stall)
endmodule

// ===== dv/dual_pulse_occupancy_dust_meter_test.sv =====
// Testbench for the dual dust meter: random and directed pin-sample and period-end items,
// checked against a built-in model of the occupancy curve and averaging filter.
// Depends on dpod_pkg and the dual_pulse_occupancy_dust_meter RTL.
`timescale 1ns / 100ps

module dual_pulse_occupancy_dust_meter_test;
    import dpod_pkg::*;

    typedef struct {
        t_opcode         op;
        logic            lvl_c;
        logic            lvl_f;
        logic [31:0]     stamp;
    } t_pin_item;

    typedef struct {
        logic [CONC_W-1:0] c;
        logic [CONC_W-1:0] f;
    } t_conc_pair;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_opcode = 1'b0;
    logic i_level_coarse = 1'b1;
    logic i_level_fine = 1'b1;
    logic [STAMP_W-1:0] i_time_us = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [CONC_W-1:0] o_conc_coarse;
    logic [CONC_W-1:0] o_conc_fine;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_index = 1'b0;
    logic [MS_W-1:0] i_cfg_data = '0;

    dual_pulse_occupancy_dust_meter i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: shared registers, one copy per channel, index 0 coarse, 1 fine.
    logic [15:0] period_ms;
    logic [7:0]  weight;
    logic        prev_lvl [2];
    logic [31:0] low_from [2];
    logic [31:0] occ_total [2];
    logic [28:0] smoothed [2];

    t_pin_item  pending_items [$];
    t_conc_pair expected_conc [$];
    int  errors = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  quiet_cycles = 0;
    bit  in_taken = 0;

    function automatic logic [28:0] occ_to_conc(logic [31:0] occ);
        logic [63:0] div, r, r2, r3, p, c;
        div = (period_ms == 0 ? 64'd1 : 64'(period_ms)) * 10;
        r = (64'(occ) << 16) / div;
        if (r > 64'(RATIO_MAX)) r = 64'(RATIO_MAX);
        r2 = (r * r) >> 16;
        r3 = (r2 * r) >> 16;
        p = 11 * r3 + 5200 * r - 38 * r2;
        c = (p << 8) / (64'd10 << 16);
        if (c > 64'(CONC_MAX)) c = 64'(CONC_MAX);
        return c[28:0];
    endfunction

    // Applies one accepted item to the predictor; a period end yields a result.
    task automatic track_item(t_pin_item it);
        logic lv [2];
        logic [63:0] w, diff, f;
        t_conc_pair pr;
        lv[0] = it.lvl_c;
        lv[1] = it.lvl_f;
        w = (weight == 0) ? 64'd1 : 64'(weight);
        for (int ch = 0; ch < 2; ch++) begin
            if (it.op == OP_SAMPLE) begin
                if (lv[ch] != prev_lvl[ch]) begin
                    prev_lvl[ch] = lv[ch];
                    if (!lv[ch]) begin
                        low_from[ch] = it.stamp;
                    end else begin
                        diff = 64'(32'(it.stamp - low_from[ch]));
                        if (diff > 64'hFFFF_FFFF - occ_total[ch]) occ_total[ch] = '1;
                        else occ_total[ch] = occ_total[ch] + diff[31:0];
                    end
                end
            end else begin
                f = (64'(occ_to_conc(occ_total[ch])) + 64'(smoothed[ch]) * (w - 1)) / w;
                smoothed[ch] = f[28:0];
                occ_total[ch] = '0;
            end
        end
        if (it.op == OP_PERIOD_END) begin
            pr.c = smoothed[0];
            pr.f = smoothed[1];
            expected_conc.push_back(pr);
        end
    endtask

    // Driver: holds the current item until it is taken, then loads the next one.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_in_valid     <= 1'b1;
                    i_opcode       <= pending_items[0].op;
                    i_level_coarse <= pending_items[0].lvl_c;
                    i_level_fine   <= pending_items[0].lvl_f;
                    i_time_us      <= pending_items[0].stamp;
                    void'(pending_items.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: feeds accepted items to the predictor and checks result items.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= i_in_valid && !o_in_stall;
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (i_in_valid && !o_in_stall) begin
                t_pin_item it;
                it.op = t_opcode'(i_opcode);
                it.lvl_c = i_level_coarse;
                it.lvl_f = i_level_fine;
                it.stamp = i_time_us;
                track_item(it);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_conc.size() == 0) begin
                    $display("%0t: unexpected result coarse=%0d fine=%0d",
                             $time, o_conc_coarse, o_conc_fine);
                    errors++;
                end else begin
                    if (o_conc_coarse !== expected_conc[0].c) begin
                        $display("%0t: conc_coarse expected %0d actual %0d",
                                 $time, expected_conc[0].c, o_conc_coarse);
                        errors++;
                    end
                    if (o_conc_fine !== expected_conc[0].f) begin
                        $display("%0t: conc_fine expected %0d actual %0d",
                                 $time, expected_conc[0].f, o_conc_fine);
                        errors++;
                    end
                    void'(expected_conc.pop_front());
                end
            end
            if (quiet_cycles > 20000) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Waits until every queued item is taken and every result has come back.
    // A period end is taken well before its result, so also let the lanes settle.
    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_conc.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_index idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_SAMPLE_MS) period_ms = val;
        else weight = val[7:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void add_item(t_opcode op, logic lc, logic lf, logic [31:0] t);
        t_pin_item it;
        it.op = op;
        it.lvl_c = lc;
        it.lvl_f = lf;
        it.stamp = t;
        pending_items.push_back(it);
    endfunction

    // Adds one sampling period: pulses on both pins with random widths, then the end.
    // Wide pulse mode produces large totals so that the ratio and curve saturate.
    function automatic void add_period(int pulses, bit wide);
        logic [31:0] t;
        logic lc, lf;
        t = $urandom;
        lc = 1'b1;
        lf = 1'b1;
        for (int k = 0; k < pulses; k++) begin
            if ($urandom_range(9) == 0) begin
                add_item(OP_SAMPLE, 1'($urandom), 1'($urandom), $urandom);
            end else begin
                t = t + (wide ? $urandom : $urandom_range(200000));
                if ($urandom_range(3) != 0) lc = ~lc;
                if ($urandom_range(3) != 0) lf = ~lf;
                add_item(OP_SAMPLE, lc, lf, t);
            end
        end
        add_item(OP_PERIOD_END, 1'($urandom), 1'($urandom), $urandom);
    endfunction

    initial begin
        period_ms = SAMPLE_MS_RST;
        weight = WEIGHT_RST;
        for (int ch = 0; ch < 2; ch++) begin
            prev_lvl[ch] = 1'b1;
            low_from[ch] = '0;
            occ_total[ch] = '0;
            smoothed[ch] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty period, unchanged levels, a wrapping pulse, the end
        // item's ignored fields, and a total pushed into saturation.
        add_item(OP_PERIOD_END, 1'b0, 1'b0, '1);
        add_item(OP_SAMPLE, 1'b1, 1'b1, 32'd5);
        add_item(OP_SAMPLE, 1'b0, 1'b0, 32'hFFFF_FFF0);
        add_item(OP_SAMPLE, 1'b0, 1'b0, 32'd7);
        add_item(OP_SAMPLE, 1'b1, 1'b0, 32'h0000_0100);
        add_item(OP_PERIOD_END, 1'b1, 1'b1, 32'h1234_5678);
        add_item(OP_SAMPLE, 1'b1, 1'b1, 32'd0);
        add_item(OP_SAMPLE, 1'b0, 1'b1, 32'd0);
        add_item(OP_SAMPLE, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_item(OP_SAMPLE, 1'b0, 1'b1, 32'd0);
        add_item(OP_SAMPLE, 1'b1, 1'b1, 32'hFFFF_FFFF);
        add_item(OP_PERIOD_END, 1'b0, 1'b1, 32'd0);
        drain();

        // Each phase brings new register values, extremes first, and its own idling.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            case (ph)
                0: begin write_reg(REG_SAMPLE_MS, 16'd1); write_reg(REG_FILTER_WEIGHT, 16'd1); end
                1: begin write_reg(REG_SAMPLE_MS, 16'hFFFF); write_reg(REG_FILTER_WEIGHT, 16'd255); end
                2: begin write_reg(REG_SAMPLE_MS, 16'd0); write_reg(REG_FILTER_WEIGHT, 16'd0); end
                default: begin
                    write_reg(REG_SAMPLE_MS, 16'($urandom_range(65535, 1)));
                    write_reg(REG_FILTER_WEIGHT, 16'($urandom_range(255, 1)));
                end
            endcase
            for (int n = 0; n < 14; n++)
                add_period($urandom_range(14), (ph == 0 || $urandom_range(7) == 0));
            // Hold the sender back until every result of the first half is in.
            if (ph == 5) drain();
            drain();
        end
        if (errors == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dpod_pkg.sv
hw/rtl/dpod_div.sv
hw/rtl/dpod_lane.sv
hw/rtl/dual_pulse_occupancy_dust_meter.sv
dv/dual_pulse_occupancy_dust_meter_test.sv
